@@ src/xild_pkg.sv @@
// ----------------------------------------------------------------------------
// xild_pkg
// Types, opcode constants and the length decode function for the x86
// instruction length decoder.
// ----------------------------------------------------------------------------
package xild_pkg;

    localparam logic [7:0] OP_FS_SEG   = 8'h64;
    localparam logic [7:0] OP_GS_SEG   = 8'h65;
    localparam logic [7:0] OP_OPSIZE   = 8'h66;
    localparam logic [7:0] OP_ADSIZE   = 8'h67;
    localparam logic [7:0] OP_LOCK     = 8'hF0;
    localparam logic [7:0] OP_REPNE    = 8'hF2;
    localparam logic [7:0] OP_REP      = 8'hF3;
    localparam logic [7:0] OP_TWO_BYTE = 8'h0F;
    localparam logic [7:0] OP_BT_IMM   = 8'hBA;
    localparam logic [7:0] OP_SHLD_IMM = 8'hA4;
    localparam logic [7:0] OP_SHRD_IMM = 8'hAC;
    localparam logic [7:0] OP_RET_IMM  = 8'hC2;
    localparam logic [7:0] OP_GRP1_IZ  = 8'h81;
    localparam logic [7:0] OP_MOV_IZ   = 8'hC7;
    localparam logic [7:0] OP_JMP_REL  = 8'hE9;
    localparam logic [7:0] OP_CALL_REL = 8'hE8;
    localparam logic [7:0] OP_JMP_SH   = 8'hEB;
    localparam logic [7:0] OP_PUSH_IB  = 8'h6A;
    localparam logic [7:0] OP_PUSH_IZ  = 8'h68;
    localparam logic [7:0] OP_NOP      = 8'h90;
    localparam logic [7:0] OP_RET      = 8'hC3;
    localparam logic [7:0] OP_INT3     = 8'hCC;
    localparam logic [7:0] OP_GRP3_B   = 8'hF6;
    localparam logic [7:0] OP_GRP3_V   = 8'hF7;
    localparam logic [7:0] MODRM_REG_M = 8'h38;

    localparam int unsigned LEN_W = 4;

    typedef logic [LEN_W-1:0] len_t;

    typedef struct packed {
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic [7:0] byte2;
        logic [7:0] byte3;
    } in_item_t;

    typedef struct packed {
        len_t instr_length;
    } out_item_t;

    function automatic logic is_prefix(input logic [7:0] b);
        return (b == OP_FS_SEG) || (b == OP_GS_SEG) || (b == OP_OPSIZE) ||
               (b == OP_ADSIZE) || (b == OP_LOCK) || (b == OP_REPNE) ||
               (b == OP_REP);
    endfunction

    // ModR/M byte plus SIB and displacement
    function automatic len_t modrm_len(input logic [7:0] m);
        logic [1:0] md;
        logic [2:0] rm;
        len_t       n;
        md = m[7:6];
        rm = m[2:0];
        case (md)
            2'd0:    n = (rm == 3'd5) ? len_t'(5) : ((rm == 3'd4) ? len_t'(2) : len_t'(1));
            2'd1:    n = (rm == 3'd4) ? len_t'(3) : len_t'(2);
            2'd2:    n = (rm == 3'd4) ? len_t'(6) : len_t'(5);
            default: n = len_t'(1);
        endcase
        return n;
    endfunction

    function automatic logic takes_modrm(input logic [7:0] op);
        logic alu_rows;
        alu_rows = (op[7:6] == 2'b00) && (op[2] == 1'b0);
        return alu_rows ||
               (op[7:4] == 4'h8) ||
               (op == 8'hC0) || (op == 8'hC1) || (op == 8'hC6) || (op == OP_MOV_IZ) ||
               (op[7:2] == 6'b110100) ||
               (op == OP_GRP3_B) || (op == OP_GRP3_V) ||
               (op == 8'hFE) || (op == 8'hFF);
    endfunction

    function automatic len_t decode_length(input in_item_t it);
        logic       pre;
        logic [7:0] op;
        logic [7:0] nx1;
        logic [7:0] nx2;
        len_t       base;
        len_t       len;
        pre  = is_prefix(it.byte0);
        op   = pre ? it.byte1 : it.byte0;
        nx1  = pre ? it.byte2 : it.byte1;
        nx2  = pre ? it.byte3 : it.byte2;
        base = len_t'(pre) + len_t'(1);
        if (op[7:4] == 4'h5 || op == OP_NOP || op == OP_RET || op == OP_INT3)
            len = base;
        else if (op == OP_RET_IMM)
            len = base + len_t'(2);
        else if (op == OP_PUSH_IB || op == OP_JMP_SH || op[7:4] == 4'h7 ||
                 op[7:3] == 5'b10110)
            len = base + len_t'(1);
        else if (op == OP_PUSH_IZ || op == OP_JMP_REL || op == OP_CALL_REL ||
                 op[7:3] == 5'b10111)
            len = base + len_t'(4);
        else if (op[7:3] == 5'b10010)
            len = base;
        else if (takes_modrm(op)) begin
            len = base + modrm_len(nx1);
            if (op == 8'h80 || op == 8'h82 || op == 8'h83 || op == 8'hC0 ||
                op == 8'hC1 || op == 8'hC6)
                len = len + len_t'(1);
            else if (op == OP_GRP1_IZ || op == OP_MOV_IZ)
                len = len + len_t'(4);
            else if (op == OP_GRP3_B && (nx1 & MODRM_REG_M) == 8'h00)
                len = len + len_t'(1);
            else if (op == OP_GRP3_V && (nx1 & MODRM_REG_M) == 8'h00)
                len = len + len_t'(4);
        end
        else if (op == OP_TWO_BYTE) begin
            len = base + len_t'(1) + modrm_len(nx2);
            if (nx1 == OP_BT_IMM || nx1 == OP_SHLD_IMM || nx1 == OP_SHRD_IMM ||
                nx1 == OP_RET_IMM)
                len = len + len_t'(1);
        end
        else
            len = base;
        return len;
    endfunction

endpackage

@@ src/xild_stream_if.sv @@
// ----------------------------------------------------------------------------
// xild_stream_if
// Valid/ready channel carrying one payload item per transaction.
// ----------------------------------------------------------------------------
interface xild_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ src/x86_instruction_length_decode_core.sv @@
// ----------------------------------------------------------------------------
// x86_instruction_length_decode_core
// Gives the length of the 32-bit x86 instruction at the start of a
// four-byte code window.
//
// req carries the window (byte0 first); rsp carries instr_length, 1 to 12.
// Both are valid/ready channels; a transaction completes when valid and
// ready are high at a rising edge of clk.
// The window is held in one register and the length in another, with the
// decode between them. Throughput: one window per cycle while rsp is not
// stalled. When rsp is stalled the result register holds and the window
// register still fills if it is empty, so at most one further window is
// taken before req.ready drops.
// rst_n clears both valid flags asynchronously; no window is in flight
// after reset and no result is lost otherwise.
// ----------------------------------------------------------------------------
module x86_instruction_length_decode_core (
    input  logic          clk,
    input  logic          rst_n,
    xild_stream_if.sink   req,
    xild_stream_if.source rsp
);
    import xild_pkg::*;

    logic      win_valid_reg;
    in_item_t  win_reg;
    logic      res_valid_reg;
    out_item_t res_reg;
    logic      res_load;
    logic      win_load;

    // result register takes a new value when empty or being drained
    assign res_load  = !res_valid_reg || rsp.ready;
    assign req.ready = !win_valid_reg || res_load;
    assign win_load  = req.valid && req.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.ready)
                win_valid_reg <= req.valid;
            if (res_load)
                res_valid_reg <= win_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (win_load)
            win_reg <= req.data;
        if (res_load && win_valid_reg)
            res_reg.instr_length <= decode_length(win_reg);
    end

    assign rsp.valid = res_valid_reg;
    assign rsp.data  = res_reg;

    a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (rsp.data.instr_length != len_t'(0) &&
                       rsp.data.instr_length <= len_t'(12)))
        else $error("instr_length out of range");

    a_win_taken: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> win_valid_reg)
        else $error("accepted window not held");

    a_win_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (win_valid_reg && res_load) |=> rsp.valid)
        else $error("decoded window produced no result");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (win_valid_reg && !res_load) |-> !req.ready)
        else $error("window register overwritten while stalled");

endmodule
